>>> sv/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and constants of the nearest point search unit
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_cmd;

endpackage

>>> sv/nearest_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// brute force 2d nearest neighbor search over a loaded point set
//
// channel  dir  tdata                          tuser
// s_axis   in   coord_x[15:0] coord_y[31:16]   kind[1:0]
// m_axis   out  near_x[15:0]  near_y[31:16]    found[0]
//
// clear and load words are carried out by the back end when taken from the queue
// a query reads one stored point per cycle
// from the point ram through a three stage distance pipeline
// an empty set answers with found = 0
// synchronous active low reset empties the set, the queue and the output
// a four word queue lets input flow while the scan or the output stalls
// ----------------------------------------------------------------------------
module nearest_point_search_unit
    import nps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [SQ_BITS-1:0] s_axis_tdata,  // coord_x, coord_y
    input  logic [1:0]         s_axis_tuser,  // kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [SQ_BITS-1:0] m_axis_tdata,  // near_x, near_y
    output logic [0:0]         m_axis_tuser   // found
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    nps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    nps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> sv/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// accepts input words, drops unused kinds and queues commands for the back end
// ----------------------------------------------------------------------------
module nps_front
    import nps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SQ_BITS-1:0]    s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);

    t_cmd                  r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                  w_push;
    logic                  w_pop;
    t_cmd                  w_new;

    assign s_axis_tready = (r_cnt != Q_CNT_BITS'(Q_DEPTH));
    assign w_new.op      = s_axis_tuser;
    assign w_new.x       = s_axis_tdata[COORD_BITS-1:0];
    assign w_new.y       = s_axis_tdata[SQ_BITS-1:COORD_BITS];
    assign w_push        = s_axis_tvalid && s_axis_tready && (s_axis_tuser != KIND_NONE);
    assign o_cmd_valid   = (r_cnt != '0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + Q_CNT_BITS'(w_push) - Q_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_new;
        end
    end

endmodule

>>> sv/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// point store, pipelined distance scan and result register
// ----------------------------------------------------------------------------
module nps_back
    import nps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [SQ_BITS-1:0] m_axis_tdata,
    output logic [0:0]         m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [CNT_BITS-1:0]          r_count, n_count;
    logic [CNT_BITS-1:0]          r_rd_idx, n_rd_idx;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic                         r_v1, r_v2, r_v3;
    logic [COORD_BITS-1:0]        r_dx, r_dy;
    logic [SQ_BITS-1:0]           r_sx, r_sy;
    logic [SQ_BITS-1:0]           r_p2, r_p3;
    logic                         r_have;
    logic [DIST_BITS-1:0]         r_best_d;
    logic [SQ_BITS-1:0]           r_best_p;
    logic                         r_out_valid;
    logic [SQ_BITS-1:0]           r_out_data;
    logic                         r_out_found;

    logic                         w_pop;
    logic                         w_wr_en;
    logic                         w_rd_en;
    logic [SQ_BITS-1:0]           w_rd_data;
    logic signed [COORD_BITS-1:0] w_px, w_py;
    logic signed [COORD_BITS:0]   w_ddx, w_ddy;
    logic [DIST_BITS-1:0]         w_sum;
    logic                         w_load_out;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_wr_en     = w_pop && (i_cmd.op == KIND_LOAD) && (r_count < CNT_BITS'(MAX_POINTS));
    assign w_rd_en     = (r_state == ST_SCAN) && (r_rd_idx < r_count);

    nps_ram #(
        .WIDTH (SQ_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_BITS-1:0]),
        .i_wr_data ({i_cmd.y, i_cmd.x}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[IDX_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_px  = w_rd_data[COORD_BITS-1:0];
    assign w_py  = w_rd_data[SQ_BITS-1:COORD_BITS];
    assign w_ddx = {w_px[COORD_BITS-1], w_px} - {r_qx[COORD_BITS-1], r_qx};
    assign w_ddy = {w_py[COORD_BITS-1], w_py} - {r_qy[COORD_BITS-1], r_qy};
    assign w_sum = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    case (i_cmd.op)
                        KIND_CLEAR: n_count = '0;
                        KIND_LOAD: begin
                            if (w_wr_en) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            n_rd_idx = '0;
                            n_state  = (r_count == '0) ? ST_FIN : ST_SCAN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end else if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_v1     <= w_rd_en;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            if (w_pop && (i_cmd.op == KIND_QUERY)) begin
                r_have <= 1'b0;
            end else if (r_v3 && (!r_have || (w_sum < r_best_d))) begin
                r_have <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (i_cmd.op == KIND_QUERY)) begin
            r_qx <= i_cmd.x;
            r_qy <= i_cmd.y;
        end
        // abs difference, then squares, then sum and compare
        r_dx <= COORD_BITS'(w_ddx[COORD_BITS] ? -w_ddx : w_ddx);
        r_dy <= COORD_BITS'(w_ddy[COORD_BITS] ? -w_ddy : w_ddy);
        r_p2 <= w_rd_data;
        r_sx <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
        r_sy <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
        r_p3 <= r_p2;
        if (r_v3 && (!r_have || (w_sum < r_best_d))) begin
            r_best_d <= w_sum;
            r_best_p <= r_p3;
        end
        if (w_load_out) begin
            r_out_data  <= r_have ? r_best_p : '0;
            r_out_found <= r_have;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_found;

endmodule

>>> sv/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// port level checks of the nearest point search unit
// ----------------------------------------------------------------------------
module nps_checker
    import nps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [SQ_BITS-1:0] s_axis_tdata,
    input logic [1:0]         s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [SQ_BITS-1:0] m_axis_tdata,
    input logic [0:0]         m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed under stall");

    // empty set reports zero coordinates
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("not found result carries coordinates");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // reset leaves the queue open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tuser))
        else $error("input word changed under stall");

endmodule

bind nearest_point_search_unit nps_checker u_nps_checker (.*);
